// File: hw/rtl/cnp_pkg.sv
`default_nettype none
package cnp_pkg;

  localparam int unsigned RadiusWidth = 15;
  localparam int unsigned AngleWidth  = 32;
  localparam int unsigned RotFrac     = 24;
  localparam int unsigned AtanDepth   = 24;
  localparam int unsigned NumLanes    = 3;
  localparam logic [31:0] GainInfQ32  = 32'd2608131496;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] ThreeQuarterTurn = 32'hC000_0000;

  typedef logic [AngleWidth-1:0] angle_t;
  typedef logic [15:0]           turn16_t;

  function automatic angle_t atan_turn(input int unsigned idx);
    angle_t a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cnp_if.sv
`default_nettype none
interface cnp_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_a_x;
  logic signed [COORD_WIDTH-1:0] point_a_y;
  logic signed [COORD_WIDTH-1:0] point_b_x;
  logic signed [COORD_WIDTH-1:0] point_b_y;
  logic signed [COORD_WIDTH-1:0] point_c_x;
  logic signed [COORD_WIDTH-1:0] point_c_y;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;

  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, center_x, center_y, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                point_c_x, point_c_y, center_x, center_y, output ready);
endinterface

interface cnp_out_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] predicted_x;
  logic signed [COORD_WIDTH-1:0] predicted_y;

  modport source (output valid, predicted_x, predicted_y, input ready);
  modport sink (input valid, predicted_x, predicted_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cnp_vector_lane.sv
`default_nettype none
module cnp_vector_lane #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_WIDTH   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] pt_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pt_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctr_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctr_y_i,
  output cnp_pkg::turn16_t                   angle_o
);
  import cnp_pkg::*;

  localparam int unsigned Stages = (CORDIC_STAGES < AtanDepth) ? CORDIC_STAGES : AtanDepth;
  localparam int unsigned DW = COORD_WIDTH + 1;
  // Vectoring datapath: 41-bit scaled differences, growth of two bits plus sign.
  localparam int unsigned VW = 44;
  localparam int unsigned PreShift = 40 - COORD_WIDTH;

  logic signed [VW-1:0] x_q [Stages+1];
  logic signed [VW-1:0] y_q [Stages+1];
  angle_t               z_q [Stages+1];
  logic                 zero_q [Stages+1];

  logic signed [DW-1:0] dx, dy;
  logic signed [VW-1:0] xs, ys;

  always_comb begin
    dx = DW'(pt_x_i) - DW'(ctr_x_i);
    dy = DW'(pt_y_i) - DW'(ctr_y_i);
    xs = VW'(dx) <<< PreShift;
    ys = VW'(dy) <<< PreShift;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x_q[0] <= -xs;
        y_q[0] <= -ys;
        z_q[0] <= HalfTurn;
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][VW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end
      end
    end
  end

  angle_t z_round;
  always_comb begin
    z_round = z_q[Stages] + angle_t'(32'h8000);
    angle_o = zero_q[Stages] ? '0 : z_round[31:16];
  end

endmodule
`default_nettype wire

// File: hw/rtl/cnp_merge.sv
`default_nettype none
module cnp_merge (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire cnp_pkg::turn16_t ta_i,
  input  wire cnp_pkg::turn16_t tb_i,
  input  wire cnp_pkg::turn16_t tc_i,
  output cnp_pkg::angle_t       z_o,
  output logic                  negate_o
);
  import cnp_pkg::*;

  turn16_t     d0, d1, nxt;
  logic [16:0] dsum;
  angle_t      t32;

  always_comb begin
    d0   = tb_i - ta_i;
    d1   = tc_i - tb_i;
    dsum = {1'b0, d0} + {1'b0, d1};
    nxt  = tc_i + dsum[16:1];
    t32  = {nxt, 16'h0000};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (t32 >= QuarterTurn && t32 < ThreeQuarterTurn) begin
        z_o      <= t32 - HalfTurn;
        negate_o <= 1'b1;
      end else begin
        z_o      <= t32;
        negate_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cnp_rotate.sv
`default_nettype none
module cnp_rotate #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_WIDTH   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [cnp_pkg::RadiusWidth-1:0] radius_i,
  input  wire cnp_pkg::angle_t               z_i,
  input  wire logic                          negate_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctr_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctr_y_i,
  output logic signed [COORD_WIDTH-1:0]      pred_x_o,
  output logic signed [COORD_WIDTH-1:0]      pred_y_o
);
  import cnp_pkg::*;

  localparam int unsigned Stages = (CORDIC_STAGES < AtanDepth) ? CORDIC_STAGES : AtanDepth;
  localparam logic [63:0] GainCorr = (64'd2 * 64'(GainInfQ32)) / (64'd3 << (2 * CORDIC_STAGES));
  localparam logic [33:0] Gain = 34'(64'(GainInfQ32) + GainCorr);
  localparam int unsigned RW = 44;
  localparam int unsigned SW = RW - RotFrac + 1;
  localparam int unsigned Lat = Stages + 2;

  logic [48:0]           prod;
  logic signed [RW-1:0]  x_q [Stages+1];
  logic signed [RW-1:0]  y_q [Stages+1];
  logic signed [33:0]    z_q [Stages+1];
  logic                  neg_q [Stages+1];
  logic signed [COORD_WIDTH-1:0] cx_q [Lat];
  logic signed [COORD_WIDTH-1:0] cy_q [Lat];

  assign prod = 49'(radius_i) * 49'(Gain);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= RW'(prod >> (32 - RotFrac));
      y_q[0]   <= '0;
      z_q[0]   <= 34'(signed'(z_i));
      neg_q[0] <= negate_i;
      cx_q[0]  <= ctr_x_i;
      cy_q[0]  <= ctr_y_i;
    end
  end

  for (genvar k = 1; k < Lat; k++) begin : g_ctr
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[k] <= cx_q[k-1];
        cy_q[k] <= cy_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - 34'(atan_turn(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + 34'(atan_turn(i));
        end
      end
    end
  end

  logic signed [RW-1:0] xf, yf;
  logic signed [SW-1:0] xr_q, yr_q;
  always_comb begin
    xf = neg_q[Stages] ? -x_q[Stages] : x_q[Stages];
    yf = neg_q[Stages] ? -y_q[Stages] : y_q[Stages];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr_q <= SW'((xf + (RW'(1) <<< (RotFrac - 1))) >>> RotFrac);
      yr_q <= SW'((yf + (RW'(1) <<< (RotFrac - 1))) >>> RotFrac);
    end
  end

  localparam int unsigned PW = ((SW > COORD_WIDTH) ? SW : COORD_WIDTH) + 1;
  localparam logic signed [PW-1:0] Hi = PW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [PW-1:0] Lo = PW'(-(64'sd1 <<< (COORD_WIDTH - 1)));
  logic signed [PW-1:0] px, py;

  always_comb begin
    px = PW'(xr_q) + PW'(cx_q[Lat-1]);
    py = PW'(yr_q) + PW'(cy_q[Lat-1]);
    pred_x_o = (px > Hi) ? Hi[COORD_WIDTH-1:0] : (px < Lo) ? Lo[COORD_WIDTH-1:0]
             : px[COORD_WIDTH-1:0];
    pred_y_o = (py > Hi) ? Hi[COORD_WIDTH-1:0] : (py < Lo) ? Lo[COORD_WIDTH-1:0]
             : py[COORD_WIDTH-1:0];
  end

endmodule
`default_nettype wire

// File: hw/rtl/circle_next_point_predictor_core.sv
// Channel  | Dir | Payload
// in_if    | in  | point_a/b/c x,y and center x,y, signed Q12.4
// out_if   | out | predicted_x, predicted_y, signed Q12.4, saturated
// cfg      | in  | radius_we_i / radius_i, 15-bit radius
// One transfer is accepted per cycle while the output is not stalled; results pass
// through the three parallel vectoring lanes, the merge stage and the rotator.
// The whole pipeline advances only when its last stage is empty or taken, so
// a stall on the output holds every stage. Reset clears the valid bits and
// the radius register.
`default_nettype none
module circle_next_point_predictor_core #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_WIDTH   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            radius_we_i,
  input  wire logic [cnp_pkg::RadiusWidth-1:0] radius_i,
  cnp_in_if.sink                               in_if,
  cnp_out_if.source                            out_if
);
  import cnp_pkg::*;

  localparam int unsigned Stages = (CORDIC_STAGES < AtanDepth) ? CORDIC_STAGES : AtanDepth;
  localparam int unsigned Depth = 2 * Stages + 4;

  logic [RadiusWidth-1:0] radius_q;
  logic [Depth-1:0]       vld_q;
  logic                   en;
  turn16_t                ang [NumLanes];
  angle_t                 z_m;
  logic                   neg_m;
  logic signed [COORD_WIDTH-1:0] cx_q [Stages+2];
  logic signed [COORD_WIDTH-1:0] cy_q [Stages+2];

  assign en = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = en;
  assign out_if.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      vld_q    <= '0;
    end else begin
      if (radius_we_i) radius_q <= radius_i;
      if (en) vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  cnp_vector_lane #(.CORDIC_STAGES(CORDIC_STAGES), .COORD_WIDTH(COORD_WIDTH)) u_lane_a (
    .clk_i, .en_i(en), .pt_x_i(in_if.point_a_x), .pt_y_i(in_if.point_a_y),
    .ctr_x_i(in_if.center_x), .ctr_y_i(in_if.center_y), .angle_o(ang[0]));
  cnp_vector_lane #(.CORDIC_STAGES(CORDIC_STAGES), .COORD_WIDTH(COORD_WIDTH)) u_lane_b (
    .clk_i, .en_i(en), .pt_x_i(in_if.point_b_x), .pt_y_i(in_if.point_b_y),
    .ctr_x_i(in_if.center_x), .ctr_y_i(in_if.center_y), .angle_o(ang[1]));
  cnp_vector_lane #(.CORDIC_STAGES(CORDIC_STAGES), .COORD_WIDTH(COORD_WIDTH)) u_lane_c (
    .clk_i, .en_i(en), .pt_x_i(in_if.point_c_x), .pt_y_i(in_if.point_c_y),
    .ctr_x_i(in_if.center_x), .ctr_y_i(in_if.center_y), .angle_o(ang[2]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= in_if.center_x;
      cy_q[0] <= in_if.center_y;
    end
  end
  for (genvar k = 1; k < Stages + 2; k++) begin : g_ctr
    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[k] <= cx_q[k-1];
        cy_q[k] <= cy_q[k-1];
      end
    end
  end

  cnp_merge u_merge (
    .clk_i, .en_i(en), .ta_i(ang[0]), .tb_i(ang[1]), .tc_i(ang[2]),
    .z_o(z_m), .negate_o(neg_m));

  cnp_rotate #(.CORDIC_STAGES(CORDIC_STAGES), .COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk_i, .en_i(en), .radius_i(radius_q), .z_i(z_m), .negate_i(neg_m),
    .ctr_x_i(cx_q[Stages+1]), .ctr_y_i(cy_q[Stages+1]),
    .pred_x_o(out_if.predicted_x), .pred_y_o(out_if.predicted_y));

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result lost under stall");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input blocked with empty output");
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(in_if.valid))
    else $error("valid pipeline mismatch");

endmodule
`default_nettype wire

// File: verif/circle_next_point_predictor_core_test.sv
`default_nettype none
module circle_next_point_predictor_core_test;

  localparam int unsigned Stages = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LatencyCycles = 2 * Stages + 4;
  localparam int unsigned CycleLimit = 400000;
  localparam longint GainQ32 = 64'sd2608131496;
  localparam longint AtanTab [0:15] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
    64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
    64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861};

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, ox, oy;
  } triple_t;

  typedef struct {
    coord_t px, py;
  } point_t;

  class prediction_board;
    point_t  awaited[$];
    logic [cnp_pkg::RadiusWidth-1:0] radius_q;
    int      errors;

    function new();
      radius_q = '0;
      errors   = 0;
    endfunction

    function automatic logic [15:0] bearing(longint dx, longint dy);
      longint x, y, xs, ys;
      logic [31:0] z;
      if (dx == 0 && dy == 0) return 16'h0;
      x = dx <<< 24;
      y = dy <<< 24;
      z = 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + AtanTab[i][31:0];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - AtanTab[i][31:0];
        end
      end
      z = z + 32'h8000;
      return z[31:16];
    endfunction

    function automatic coord_t clip(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return coord_t'(v);
    endfunction

    function void note_accepted(triple_t t);
      longint ox, oy, x, y, xs, ys, z;
      logic [15:0] ta, tb, tc, d0, d1, nxt;
      logic [16:0] dsum;
      logic [31:0] t32;
      logic negate;
      point_t p;
      ox = longint'(t.ox);
      oy = longint'(t.oy);
      ta = bearing(longint'(t.ax) - ox, longint'(t.ay) - oy);
      tb = bearing(longint'(t.bx) - ox, longint'(t.by) - oy);
      tc = bearing(longint'(t.cx) - ox, longint'(t.cy) - oy);
      d0 = tb - ta;
      d1 = tc - tb;
      dsum = {1'b0, d0} + {1'b0, d1};
      nxt = tc + dsum[16:1];
      t32 = {nxt, 16'h0};
      negate = 1'b0;
      if (t32 >= 32'h4000_0000 && t32 < 32'hC000_0000) begin
        t32 = t32 - 32'h8000_0000;
        negate = 1'b1;
      end
      z = longint'($signed(t32));
      x = (longint'(radius_q) * GainQ32) >>> 8;
      y = 0;
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - AtanTab[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + AtanTab[i];
        end
      end
      if (negate) begin
        x = -x;
        y = -y;
      end
      p.px = clip(((x + (64'sd1 <<< 23)) >>> 24) + ox);
      p.py = clip(((y + (64'sd1 <<< 23)) >>> 24) + oy);
      awaited.push_back(p);
    endfunction

    function void check_result(coord_t px, coord_t py);
      point_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, px, py);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (px !== e.px) begin
        $display("%0t: predicted_x expected %0d actual %0d", $time, e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $display("%0t: predicted_y expected %0d actual %0d", $time, e.py, py);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic radius_we_i = 1'b0;
  logic [cnp_pkg::RadiusWidth-1:0] radius_i = '0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  prediction_board board = new();

  cnp_in_if #(.COORD_WIDTH(CoordW)) in_ch ();
  cnp_out_if #(.COORD_WIDTH(CoordW)) out_ch ();

  circle_next_point_predictor_core #(
    .CORDIC_STAGES(Stages),
    .COORD_WIDTH(CoordW)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .radius_we_i(radius_we_i),
    .radius_i(radius_i),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: checks each transfer, then decides readiness for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) board.check_result(out_ch.predicted_x,
                                                                  out_ch.predicted_y);
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 400;
      hold_done <= 1'b1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sent >= 500 && sent < 700) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 23);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_a_x = '0;
    in_ch.point_a_y = '0;
    in_ch.point_b_x = '0;
    in_ch.point_b_y = '0;
    in_ch.point_c_x = '0;
    in_ch.point_c_y = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send_triple(triple_t t);
    if (!(sent >= 500 && sent < 700)) begin
      while ($urandom_range(99) < 23) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.point_a_x <= t.ax;
    in_ch.point_a_y <= t.ay;
    in_ch.point_b_x <= t.bx;
    in_ch.point_b_y <= t.by;
    in_ch.point_c_x <= t.cx;
    in_ch.point_c_y <= t.cy;
    in_ch.center_x <= t.ox;
    in_ch.center_y <= t.oy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_accepted(t);
    sent++;
    if (sent == 250) hold_req <= 1'b1;
  endtask

  task automatic write_radius(logic [cnp_pkg::RadiusWidth-1:0] r);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
    radius_we_i <= 1'b1;
    radius_i <= r;
    @(posedge clk_i);
    radius_we_i <= 1'b0;
    board.radius_q = r;
  endtask

  function automatic coord_t on_ring(int o, int r, real th, logic use_cos);
    real v;
    v = real'(o) + real'(r) * (use_cos ? $cos(th) : $sin(th));
    if (v > 32767.0) v = 32767.0;
    if (v < -32768.0) v = -32768.0;
    return coord_t'($rtoi(v));
  endfunction

  function automatic triple_t arc_triple();
    triple_t t;
    int r, ox, oy;
    real th, st;
    ox = $urandom_range(24000) - 12000;
    oy = $urandom_range(24000) - 12000;
    r = ($urandom_range(3) == 0) ? $urandom_range(30000, 1) : $urandom_range(3000, 16);
    th = real'($urandom_range(62831)) / 10000.0;
    st = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
    t.ox = coord_t'(ox);
    t.oy = coord_t'(oy);
    t.ax = on_ring(ox, r, th, 1'b1);
    t.ay = on_ring(ox * 0 + oy, r, th, 1'b0);
    t.bx = on_ring(ox, r, th + st, 1'b1);
    t.by = on_ring(oy, r, th + st, 1'b0);
    t.cx = on_ring(ox, r, th + 2.0 * st, 1'b1);
    t.cy = on_ring(oy, r, th + 2.0 * st, 1'b0);
    return t;
  endfunction

  function automatic triple_t noise_triple();
    triple_t t;
    t.ax = coord_t'($urandom);
    t.ay = coord_t'($urandom);
    t.bx = coord_t'($urandom);
    t.by = coord_t'($urandom);
    t.cx = coord_t'($urandom);
    t.cy = coord_t'($urandom);
    t.ox = coord_t'($urandom);
    t.oy = coord_t'($urandom);
    return t;
  endfunction

  function automatic triple_t fixed(int ax, int ay, int bx, int by, int cx, int cy,
                                    int ox, int oy);
    triple_t t;
    t.ax = coord_t'(ax);
    t.ay = coord_t'(ay);
    t.bx = coord_t'(bx);
    t.by = coord_t'(by);
    t.cx = coord_t'(cx);
    t.cy = coord_t'(cy);
    t.ox = coord_t'(ox);
    t.oy = coord_t'(oy);
    return t;
  endfunction

  initial begin
    logic [cnp_pkg::RadiusWidth-1:0] radii [0:5];
    radii = '{15'd32767, 15'd0, 15'd1, 15'd4096, 15'd0, 15'd160};
    radii[4] = cnp_pkg::RadiusWidth'($urandom_range(32767, 2));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_radius(radii[0]);
    send_triple(fixed(0, 0, 0, 0, 0, 0, 0, 0));
    send_triple(fixed(100, 0, 100, 0, 100, 0, 100, 0));
    send_triple(fixed(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768));
    send_triple(fixed(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767));
    send_triple(fixed(-32768, 32767, 32767, -32768, -32768, -32768, 0, 0));
    send_triple(fixed(-500, 10, -500, 0, -500, -10, 0, 0));
    send_triple(fixed(-500, -40, -500, 0, -500, 40, 0, 0));
    send_triple(fixed(500, -40, 500, 0, 500, 40, 0, 0));
    send_triple(fixed(0, 500, -500, 0, 0, -500, 0, 0));
    send_triple(fixed(0, -500, 0, 500, 0, -500, 0, 0));
    send_triple(fixed(1000, 1, 1000, -1, 1000, 1, 0, 0));
    send_triple(fixed(32767, 0, 0, 32767, -32768, 0, 32767, -32768));
    send_triple(fixed(-1, -1, -1, -1, -1, -1, -1, -1));
    send_triple(fixed(21845, -21846, 10922, -10923, 0, 1, 0, 0));
    send_triple(fixed(30000, 30000, 30000, 30000, 30000, 30000, 30000, 30000));
    send_triple(fixed(200, 200, 200, 200, 200, 200, 32767, 32767));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) write_radius(radii[ph]);
      for (int k = 0; k < 185; k++) begin
        if ($urandom_range(99) < 70) send_triple(arc_triple());
        else send_triple(noise_triple());
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/cnp_pkg.sv
hw/rtl/cnp_if.sv
hw/rtl/cnp_vector_lane.sv
hw/rtl/cnp_merge.sv
hw/rtl/cnp_rotate.sv
hw/rtl/circle_next_point_predictor_core.sv
verif/circle_next_point_predictor_core_test.sv
